[design/gwwlb_pkg.sv]
// ----------------------------------------------------------------------------
// gwwlb_pkg
// Shared types, character codes and break codes of the greedy word-wrap
// line breaker.
// ----------------------------------------------------------------------------
package gwwlb_pkg;

  localparam int TAIL_DEPTH_DEFAULT    = 32;
  localparam int POSITION_BITS_DEFAULT = 16;
  localparam int QUEUE_DEPTH           = 2;

  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_SPACE = 8'd32;
  localparam logic [7:0] CHAR_TAB   = 8'd9;

  typedef logic [1:0] break_kind_t;
  localparam break_kind_t KIND_LINE_END  = 2'd0;
  localparam break_kind_t KIND_WRAP_SPACE = 2'd1;
  localparam break_kind_t KIND_WRAP_WORD = 2'd2;
  localparam break_kind_t KIND_OVERFLOW  = 2'd3;

  typedef logic [1:0] char_class_t;
  localparam char_class_t CLS_GLYPH = 2'd0;
  localparam char_class_t CLS_SPACE = 2'd1;
  localparam char_class_t CLS_CR    = 2'd2;
  localparam char_class_t CLS_LF    = 2'd3;

  typedef logic [1:0] reg_index_t;
  localparam reg_index_t REG_WRAP_ENABLE    = 2'd0;
  localparam reg_index_t REG_WRAP_WIDTH     = 2'd1;
  localparam reg_index_t REG_START_POSITION = 2'd2;

  typedef struct packed {
    logic [7:0] char_code;
    logic [7:0] glyph_width;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [15:0] break_position;
    break_kind_t break_kind;
    logic        last_of_run;
  } out_item_t;

  // Classified character as it travels from front to back
  typedef struct packed {
    char_class_t cls;
    logic [7:0]  width;
    logic        eot;
  } class_item_t;

  // Decoded configuration write
  typedef struct packed {
    logic        wr_enable;
    logic        wr_width;
    logic        wr_start;
    logic [15:0] data;
  } cfg_write_t;

endpackage

[design/gwwlb_front.sv]
// ----------------------------------------------------------------------------
// gwwlb_front
// Accepts characters, classifies them and tags each with its text position.
// ----------------------------------------------------------------------------
module gwwlb_front #(
  parameter int POSITION_BITS = gwwlb_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gwwlb_pkg::cfg_write_t     cfg,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  gwwlb_pkg::in_item_t       in_data,
  input  logic                      q_full,
  output logic                      push,
  output gwwlb_pkg::class_item_t    push_item,
  output logic [POSITION_BITS-1:0]  push_pos
);

  logic [POSITION_BITS-1:0] pos_r;
  logic [POSITION_BITS-1:0] pos_nxt;
  logic [15:0]              start_r;
  gwwlb_pkg::char_class_t   cls;

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    case (in_data.char_code)
      gwwlb_pkg::CHAR_CR:    cls = gwwlb_pkg::CLS_CR;
      gwwlb_pkg::CHAR_LF:    cls = gwwlb_pkg::CLS_LF;
      gwwlb_pkg::CHAR_SPACE,
      gwwlb_pkg::CHAR_TAB:   cls = gwwlb_pkg::CLS_SPACE;
      default:               cls = gwwlb_pkg::CLS_GLYPH;
    endcase
  end

  assign push_item.cls   = cls;
  assign push_item.width = in_data.glyph_width;
  assign push_item.eot   = in_data.end_of_text;
  assign push_pos        = pos_r;

  // reload the start position after the final character of a text
  assign pos_nxt = in_data.end_of_text ? POSITION_BITS'(start_r)
                                       : pos_r + POSITION_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      start_r <= '0;
    end else if (cfg.wr_start) begin
      start_r <= cfg.data;
      pos_r   <= POSITION_BITS'(cfg.data);
    end else if (push) begin
      pos_r <= pos_nxt;
    end
  end

endmodule

[design/gwwlb_queue.sv]
// ----------------------------------------------------------------------------
// gwwlb_queue
// Short request queue between the classifying front and the break engine.
// ----------------------------------------------------------------------------
module gwwlb_queue #(
  parameter int DATA_BITS = $bits(gwwlb_pkg::class_item_t)
                            + gwwlb_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  logic [DATA_BITS-1:0] push_data,
  output logic                 full,
  input  logic                 pop,
  output logic                 head_valid,
  output logic [DATA_BITS-1:0] head_data
);

  localparam int Depth    = gwwlb_pkg::QUEUE_DEPTH;
  localparam int PtrBits  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntBits  = $clog2(Depth + 1);

  logic [DATA_BITS-1:0] entries_r [Depth];
  logic [PtrBits-1:0]   wr_ptr_r;
  logic [PtrBits-1:0]   rd_ptr_r;
  logic [CntBits-1:0]   count_r;

  assign full       = (count_r == CntBits'(Depth));
  assign head_valid = (count_r != '0);
  assign head_data  = entries_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PtrBits'(Depth - 1)) ? '0 : wr_ptr_r + PtrBits'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PtrBits'(Depth - 1)) ? '0 : rd_ptr_r + PtrBits'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CntBits'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CntBits'(1);
      end
    end
  end

endmodule

[design/gwwlb_back.sv]
// ----------------------------------------------------------------------------
// gwwlb_back
// Break engine: keeps the line state, buffers the word tail, re-walks it
// after a wrap behind a space and delivers breaks through an output register.
// ----------------------------------------------------------------------------
module gwwlb_back #(
  parameter int TAIL_DEPTH    = gwwlb_pkg::TAIL_DEPTH_DEFAULT,
  parameter int POSITION_BITS = gwwlb_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  gwwlb_pkg::cfg_write_t     cfg,
  input  logic                      head_valid,
  input  gwwlb_pkg::class_item_t    head_item,
  input  logic [POSITION_BITS-1:0]  head_pos,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output gwwlb_pkg::out_item_t      out_data
);

  localparam int IdxBits = $clog2(TAIL_DEPTH);
  localparam int CntBits = $clog2(TAIL_DEPTH + 1);

  localparam logic [1:0] ST_HEAD   = 2'd0;
  localparam logic [1:0] ST_REWALK = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;

  // configuration
  logic        wrap_en_r;
  logic [15:0] wrap_width_r;

  // line state
  logic [1:0]               state_r, state_nxt;
  logic [15:0]              lw_r, lw_nxt;
  logic                     bv_r, bv_nxt;
  logic [POSITION_BITS-1:0] bp_r, bp_nxt;
  logic [CntBits-1:0]       tc_r, tc_nxt;
  logic                     pcr_r, pcr_nxt;
  logic [CntBits-1:0]       n_r, n_nxt;
  logic [CntBits-1:0]       idx_r, idx_nxt;
  logic [POSITION_BITS-1:0] q_r, q_nxt;

  // tail store
  logic [7:0] tail_mem [TAIL_DEPTH];
  logic [7:0] rd_data_r;
  logic       mem_we;

  // result staging
  logic                     held_v_r, held_v_nxt;
  gwwlb_pkg::out_item_t     held_r, held_nxt;
  logic                     out_valid_r;
  gwwlb_pkg::out_item_t     out_data_r;
  logic                     out_load;
  gwwlb_pkg::out_item_t     out_load_data;
  logic                     out_free;

  // step signals
  logic                     step_act;
  logic                     step_done;
  logic                     res_v;
  logic [POSITION_BITS-1:0] res_pos;
  gwwlb_pkg::break_kind_t   res_kind;
  logic [1:0]               step_state;
  logic                     need_out;
  logic                     adv;
  gwwlb_pkg::out_item_t     res_item;

  // helpers
  logic                     is_space;
  logic                     bv_e;
  logic [POSITION_BITS-1:0] bp_e;
  logic [CntBits-1:0]       tc_e;
  logic [16:0]              sum_head;
  logic                     fit_head;
  logic                     at_cur;
  logic [7:0]               rw_w;
  logic [POSITION_BITS-1:0] rw_pos;
  logic [16:0]              sum_rw;
  logic                     fit_rw;
  logic [POSITION_BITS-1:0] pos_inc;
  logic [15:0]              base_lw;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_space = (head_item.cls == gwwlb_pkg::CLS_SPACE);
  assign bv_e     = is_space ? 1'b1 : bv_r;
  assign bp_e     = is_space ? head_pos : bp_r;
  assign tc_e     = is_space ? '0 : tc_r;
  assign pos_inc  = head_pos + POSITION_BITS'(1);
  assign sum_head = {1'b0, lw_r} + 17'(head_item.width);
  assign fit_head = !wrap_en_r || (lw_r == '0) || (sum_head <= {1'b0, wrap_width_r});

  assign at_cur   = (idx_r == n_r);
  assign rw_w     = at_cur ? head_item.width : rd_data_r;
  assign rw_pos   = at_cur ? head_pos : q_r;
  assign sum_rw   = {1'b0, lw_r} + 17'(rw_w);
  assign fit_rw   = !wrap_en_r || (lw_r == '0) || (sum_rw <= {1'b0, wrap_width_r});

  always_comb begin
    state_nxt  = state_r;
    lw_nxt     = lw_r;
    bv_nxt     = bv_r;
    bp_nxt     = bp_r;
    tc_nxt     = tc_r;
    pcr_nxt    = pcr_r;
    n_nxt      = n_r;
    idx_nxt    = idx_r;
    q_nxt      = q_r;
    mem_we     = 1'b0;
    step_act   = 1'b0;
    step_done  = 1'b0;
    res_v      = 1'b0;
    res_pos    = head_pos;
    res_kind   = gwwlb_pkg::KIND_LINE_END;
    step_state = state_r;
    base_lw    = lw_r;

    case (state_r)
      ST_HEAD: begin
        step_act = head_valid;
        if (pcr_r) begin
          // resolve the CR held over from the previous character
          pcr_nxt = 1'b0;
          lw_nxt  = '0;
          bv_nxt  = 1'b0;
          bp_nxt  = '0;
          tc_nxt  = '0;
          res_v   = 1'b1;
          if (head_item.cls == gwwlb_pkg::CLS_LF) begin
            res_pos   = pos_inc;
            step_done = 1'b1;
          end
        end else begin
          case (head_item.cls)
            gwwlb_pkg::CLS_CR: begin
              lw_nxt    = '0;
              bv_nxt    = 1'b0;
              bp_nxt    = '0;
              tc_nxt    = '0;
              step_done = 1'b1;
              if (head_item.eot) begin
                res_v   = 1'b1;
                res_pos = pos_inc;
              end else begin
                pcr_nxt = 1'b1;
              end
            end
            gwwlb_pkg::CLS_LF: begin
              lw_nxt    = '0;
              bv_nxt    = 1'b0;
              bp_nxt    = '0;
              tc_nxt    = '0;
              res_v     = 1'b1;
              res_pos   = pos_inc;
              step_done = 1'b1;
            end
            default: begin
              bv_nxt = bv_e;
              bp_nxt = bp_e;
              tc_nxt = tc_e;
              if (fit_head) begin
                step_done = 1'b1;
                if (!is_space && bv_e) begin
                  if (tc_e < CntBits'(TAIL_DEPTH)) begin
                    mem_we = 1'b1;
                    tc_nxt = tc_e + CntBits'(1);
                  end else begin
                    // tail store full: drop the break point
                    bv_nxt = 1'b0;
                    tc_nxt = '0;
                    if (wrap_en_r) begin
                      res_v    = 1'b1;
                      res_kind = gwwlb_pkg::KIND_OVERFLOW;
                      base_lw  = '0;
                    end
                  end
                end
                if (base_lw == lw_r) begin
                  lw_nxt = sum_head[16] ? 16'hFFFF : sum_head[15:0];
                end else begin
                  lw_nxt = 16'(head_item.width);
                end
              end else if (!bv_e || (bp_e == head_pos)) begin
                step_done = 1'b1;
                res_v     = 1'b1;
                res_kind  = gwwlb_pkg::KIND_WRAP_WORD;
                lw_nxt    = 16'(head_item.width);
                tc_nxt    = '0;
                bv_nxt    = is_space;
                bp_nxt    = is_space ? head_pos : '0;
              end else begin
                // wrap behind the space, then re-walk the buffered tail
                res_v      = 1'b1;
                res_kind   = gwwlb_pkg::KIND_WRAP_SPACE;
                res_pos    = bp_e + POSITION_BITS'(1);
                lw_nxt     = '0;
                bv_nxt     = 1'b0;
                bp_nxt     = '0;
                tc_nxt     = '0;
                n_nxt      = tc_e;
                idx_nxt    = '0;
                q_nxt      = bp_e + POSITION_BITS'(1);
                step_state = ST_REWALK;
              end
            end
          endcase
        end
      end
      ST_REWALK: begin
        step_act = 1'b1;
        if (fit_rw) begin
          lw_nxt = sum_rw[16] ? 16'hFFFF : sum_rw[15:0];
        end else begin
          res_v    = 1'b1;
          res_kind = gwwlb_pkg::KIND_WRAP_WORD;
          res_pos  = rw_pos;
          lw_nxt   = 16'(rw_w);
        end
        if (at_cur) begin
          step_done = 1'b1;
        end else begin
          idx_nxt = idx_r + CntBits'(1);
          q_nxt   = q_r + POSITION_BITS'(1);
        end
      end
      default: begin
        step_act = 1'b0;
      end
    endcase

    // end of text: back to the start state
    if (step_done && head_item.eot) begin
      lw_nxt  = '0;
      bv_nxt  = 1'b0;
      bp_nxt  = '0;
      tc_nxt  = '0;
      pcr_nxt = 1'b0;
    end
  end

  assign res_item.break_position = 16'(res_pos);
  assign res_item.break_kind     = res_kind;
  assign res_item.last_of_run    = 1'b0;

  // A result is held back one step so that its last-of-run mark is known.
  always_comb begin
    need_out      = 1'b0;
    adv           = 1'b0;
    out_load      = 1'b0;
    out_load_data = held_r;
    held_v_nxt    = held_v_r;
    held_nxt      = held_r;
    if (state_r == ST_FLUSH) begin
      out_load                  = out_free;
      out_load_data.last_of_run = 1'b1;
      if (out_free) begin
        held_v_nxt = 1'b0;
      end
    end else if (step_act) begin
      need_out = (held_v_r && (res_v || step_done)) || (!held_v_r && res_v && step_done);
      adv      = !need_out || out_free;
      if (adv) begin
        if (held_v_r && res_v) begin
          out_load = 1'b1;
          held_nxt = res_item;
        end else if (held_v_r && step_done) begin
          out_load                  = 1'b1;
          out_load_data.last_of_run = 1'b1;
          held_v_nxt                = 1'b0;
        end else if (res_v && step_done) begin
          out_load                  = 1'b1;
          out_load_data             = res_item;
          out_load_data.last_of_run = 1'b1;
        end else if (res_v) begin
          held_v_nxt = 1'b1;
          held_nxt   = res_item;
        end
      end
    end
  end

  assign pop = adv && step_done;

  // tail store, registered read one entry ahead of the re-walk
  always_ff @(posedge clk) begin
    if (adv && mem_we) begin
      tail_mem[tc_e[IdxBits-1:0]] <= head_item.width;
    end
    rd_data_r <= tail_mem[(adv ? idx_nxt[IdxBits-1:0] : idx_r[IdxBits-1:0])];
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_load_data;
    end
    held_r <= held_nxt;
    n_r    <= adv ? n_nxt : n_r;
    q_r    <= adv ? q_nxt : q_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wrap_en_r    <= 1'b0;
      wrap_width_r <= '0;
      state_r      <= ST_HEAD;
      lw_r         <= '0;
      bv_r         <= 1'b0;
      bp_r         <= '0;
      tc_r         <= '0;
      pcr_r        <= 1'b0;
      idx_r        <= '0;
      held_v_r     <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg.wr_enable) begin
        wrap_en_r <= cfg.data[0];
      end
      if (cfg.wr_width) begin
        wrap_width_r <= cfg.data;
      end
      held_v_r <= held_v_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (state_r == ST_FLUSH) begin
        if (out_free) begin
          state_r <= ST_HEAD;
        end
      end else if (adv) begin
        lw_r  <= lw_nxt;
        bv_r  <= bv_nxt;
        bp_r  <= bp_nxt;
        tc_r  <= tc_nxt;
        pcr_r <= pcr_nxt;
        idx_r <= idx_nxt;
        if (step_done) begin
          state_r <= (held_v_r && res_v) ? ST_FLUSH : ST_HEAD;
        end else begin
          state_r <= step_state;
        end
      end
      if (cfg.wr_start) begin
        lw_r  <= '0;
        bv_r  <= 1'b0;
        bp_r  <= '0;
        tc_r  <= '0;
        pcr_r <= 1'b0;
      end
    end
  end

endmodule

[design/greedy_word_wrap_line_breaker.sv]
// A break enters the output register at the engine step that ends its item or yields the
// item's next break. The engine takes one character a cycle while the queue holds one and
// the output is free; a character behind a lone CR takes an extra step, a wrap behind a space
// re-walks the buffered glyphs, and a break behind another at an item's end adds a flush
// state; output stalls hold the engine. Reset (synchronous, rst_n low) clears control registers,
// queue and line state; the tail store is not cleared, as only entries below the count are read.
// ----------------------------------------------------------------------------
// greedy_word_wrap_line_breaker
// Greedy word-wrap line breaker: classifying front, request queue and break
// engine with its tail store and output register.
// ----------------------------------------------------------------------------
module greedy_word_wrap_line_breaker #(
  parameter int TAIL_DEPTH    = gwwlb_pkg::TAIL_DEPTH_DEFAULT,
  parameter int POSITION_BITS = gwwlb_pkg::POSITION_BITS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  gwwlb_pkg::reg_index_t  cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  gwwlb_pkg::in_item_t    in_data,
  output logic                   out_valid,
  input  logic                   out_stall,
  output gwwlb_pkg::out_item_t   out_data
);

  localparam int ItemBits = $bits(gwwlb_pkg::class_item_t);
  localparam int QBits    = ItemBits + POSITION_BITS;

  gwwlb_pkg::cfg_write_t     cfg;
  logic                      cfg_wr;
  logic                      q_full;
  logic                      push;
  gwwlb_pkg::class_item_t    push_item;
  logic [POSITION_BITS-1:0]  push_pos;
  logic                      pop;
  logic                      head_valid;
  logic [QBits-1:0]          head_data;
  gwwlb_pkg::class_item_t    head_item;
  logic [POSITION_BITS-1:0]  head_pos;

  // decode the register write; an index beyond the list is dropped
  assign cfg_ready     = 1'b1;
  assign cfg_wr        = cfg_valid && cfg_ready;
  assign cfg.wr_enable = cfg_wr && (cfg_index == gwwlb_pkg::REG_WRAP_ENABLE);
  assign cfg.wr_width  = cfg_wr && (cfg_index == gwwlb_pkg::REG_WRAP_WIDTH);
  assign cfg.wr_start  = cfg_wr && (cfg_index == gwwlb_pkg::REG_START_POSITION);
  assign cfg.data      = cfg_data;

  gwwlb_front #(
    .POSITION_BITS (POSITION_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item),
    .push_pos  (push_pos)
  );

  gwwlb_queue #(
    .DATA_BITS (QBits)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  ({push_pos, push_item}),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  assign head_item = head_data[ItemBits-1:0];
  assign head_pos  = head_data[QBits-1:ItemBits];

  gwwlb_back #(
    .TAIL_DEPTH    (TAIL_DEPTH),
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (head_valid),
    .head_item  (head_item),
    .head_pos   (head_pos),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

endmodule
